@@ rtl/skc_pkg.sv @@
// ----------------------------------------------------------------------------
// skc_pkg
// Shared types and fixed field widths of the stable key sorter.
// ----------------------------------------------------------------------------
package skc_pkg;

    localparam int TAG_WIDTH    = 6;
    localparam int IN_KEY_WIDTH = 32;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the incoming request into the sorted row
        logic shift;    // move every entry one cell toward the output
    } skc_ctrl_t;

endpackage

@@ rtl/skc_if.sv @@
// ----------------------------------------------------------------------------
// skc_if
// Valid/ready channels of the stable key sorter: input requests and results.
// ----------------------------------------------------------------------------
interface skc_in_if
    import skc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [IN_KEY_WIDTH-1:0] sort_key;
    logic [TAG_WIDTH-1:0]    element_tag;
    logic                    batch_last;

    modport source (output valid, output sort_key, output element_tag,
                     output batch_last, input ready);
    modport sink   (input valid, input sort_key, input element_tag,
                     input batch_last, output ready);
endinterface

interface skc_out_if
    import skc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [IN_KEY_WIDTH-1:0] sorted_key;
    logic [TAG_WIDTH-1:0]    sorted_tag;
    logic                    run_last;
    logic                    overflowed;

    modport source (output valid, output sorted_key, output sorted_tag,
                     output run_last, output overflowed, input ready);
    modport sink   (input valid, input sorted_key, input sorted_tag,
                     input run_last, input overflowed, output ready);
endinterface

@@ rtl/skc_cell.sv @@
// ----------------------------------------------------------------------------
// skc_cell
// One position of the sorted row: holds a key and tag, takes the new
// request or its left neighbor's entry on insert, its right neighbor's on
// shift.
// ----------------------------------------------------------------------------
module skc_cell
    import skc_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 clk,
    input  skc_ctrl_t            ctrl,
    input  logic                 occupied,
    input  logic [KEY_WIDTH-1:0] new_key,
    input  logic [TAG_WIDTH-1:0] new_tag,
    input  logic                 left_gt,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic [TAG_WIDTH-1:0] left_tag,
    input  logic [KEY_WIDTH-1:0] right_key,
    input  logic [TAG_WIDTH-1:0] right_tag,
    output logic                 gt,
    output logic [KEY_WIDTH-1:0] key,
    output logic [TAG_WIDTH-1:0] tag
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [TAG_WIDTH-1:0] tag_reg;

    // Strict compare: an equal key stays ahead of the new request
    assign gt  = !occupied || (key_reg > new_key);
    assign key = key_reg;
    assign tag = tag_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            key_reg <= right_key;
            tag_reg <= right_tag;
        end
        else if (ctrl.insert && gt)
        begin
            if (left_gt)
            begin
                key_reg <= left_key;
                tag_reg <= left_tag;
            end
            else
            begin
                key_reg <= new_key;
                tag_reg <= new_tag;
            end
        end
    end

endmodule

@@ rtl/stable_key_sorter.sv @@
// ----------------------------------------------------------------------------
// stable_key_sorter
// Stable ascending sort of a batch of key/tag requests in a chain of cells.
// ----------------------------------------------------------------------------
// A batch is collected one request per cycle into a row of CAPACITY cells that
// stays sorted at all times: every cell compares its key with the incoming one
// and either holds, takes its left neighbor's entry, or takes the new request.
// Equal keys keep arrival order. Requests past CAPACITY are dropped and the
// first result of the batch carries overflowed. After the request marked
// batch_last, the n stored entries (at most CAPACITY) leave from cell 0 one per
// cycle while out_ch.ready is high, as the row shifts toward the output; the
// input is not ready while results are draining.
module stable_key_sorter
    import skc_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    skc_in_if.sink       in_ch,
    skc_out_if.source    out_ch
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg,   ovf_next;

    logic [KEY_WIDTH+IN_KEY_WIDTH-1:0] key_in_ext;
    logic [KEY_WIDTH+IN_KEY_WIDTH-1:0] key_out_ext;
    logic [KEY_WIDTH-1:0]              new_key;

    logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [TAG_WIDTH-1:0] cell_tag [CAPACITY];
    logic                 cell_gt  [CAPACITY];

    logic      in_acc, out_acc, full;
    skc_ctrl_t ctrl;

    assign key_in_ext  = {{KEY_WIDTH{1'b0}}, in_ch.sort_key};
    assign new_key     = key_in_ext[KEY_WIDTH-1:0];
    assign key_out_ext = {{IN_KEY_WIDTH{1'b0}}, cell_key[0]};

    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;

    assign ctrl.insert = in_acc && !full;
    assign ctrl.shift  = out_acc;

    assign in_ch.ready       = (state_reg == ST_FILL);
    assign out_ch.valid      = (state_reg == ST_DRAIN);
    assign out_ch.sorted_key = key_out_ext[IN_KEY_WIDTH-1:0];
    assign out_ch.sorted_tag = cell_tag[0];
    assign out_ch.run_last   = (count_reg == CNT_W'(1));
    assign out_ch.overflowed = ovf_reg;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                 l_gt;
            logic [KEY_WIDTH-1:0] l_key, r_key;
            logic [TAG_WIDTH-1:0] l_tag, r_tag;

            if (i == 0)
            begin : g_head
                assign l_gt  = 1'b0;
                assign l_key = '0;
                assign l_tag = '0;
            end
            else
            begin : g_body
                assign l_gt  = cell_gt[i-1];
                assign l_key = cell_key[i-1];
                assign l_tag = cell_tag[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign r_key = '0;
                assign r_tag = '0;
            end
            else
            begin : g_inner
                assign r_key = cell_key[i+1];
                assign r_tag = cell_tag[i+1];
            end

            skc_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (CNT_W'(i) < count_reg),
                .new_key   (new_key),
                .new_tag   (in_ch.element_tag),
                .left_gt   (l_gt),
                .left_key  (l_key),
                .left_tag  (l_tag),
                .right_key (r_key),
                .right_tag (r_tag),
                .gt        (cell_gt[i]),
                .key       (cell_key[i]),
                .tag       (cell_tag[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_acc)
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        count_next = count_reg + CNT_W'(1);
                    if (in_ch.batch_last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_acc)
                begin
                    // overflow is reported on the first result only
                    ovf_next   = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                        state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (count_reg != '0))
        else $error("draining with no stored entries");

    a_batch_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_ch.run_last) |=> (count_reg == '0 && in_ch.ready && !ovf_reg))
        else $error("batch state not cleared after final result");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !out_ch.run_last) |=> (out_ch.valid && cell_key[0] >= $past(cell_key[0])))
        else $error("results leave out of ascending order");

endmodule
